// ----- rtl/ami_pkg.sv -----
`default_nettype none

package ami_pkg;

    // Row numbers of the first and last of the three result rows of one matrix.
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    // One divider lane per entry of a result row: three linear, one translation.
    localparam int NUM_LANES = 4;

    // Control that travels beside the datapath of one result row.
    typedef struct packed {
        logic       valid;
        logic       sing;
        logic [1:0] row_index;
        logic       last_row;
        logic       neg;
        logic       ovf;
    } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/ami_div_lane.sv -----
`default_nettype none

module ami_div_lane #(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_WIDTH  = 196
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  adv,
    input  wire ami_pkg::ctl_t         in_ctl,
    input  wire logic [NUM_WIDTH-1:0]  in_num,
    input  wire logic [NUM_WIDTH-1:0]  in_den,
    output ami_pkg::ctl_t              out_ctl,
    output logic [DATA_WIDTH-1:0]      out_col
);
    import ami_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int NW = NUM_WIDTH;
    localparam int QW = W + 1;
    localparam int NS = W + 1;

    ctl_t            ctl_reg [0:NS];
    logic [NW-1:0]   rem_reg [0:NS];
    logic [NW-1:0]   den_reg [0:NS];
    logic [QW-1:0]   quo_reg [0:NS];
    ctl_t            ctl_next;
    ctl_t            out_ctl_reg;
    logic [W-1:0]    out_col_reg;

    // A quotient that needs more than QW bits is saturated without dividing.
    always_comb begin
        ctl_next     = in_ctl;
        ctl_next.ovf = (in_num >= (in_den << QW));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (adv) begin
            ctl_reg[0] <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= in_num;
            den_reg[0] <= in_den;
            quo_reg[0] <= '0;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam int K = W - s;
        logic [NW-1:0] shifted;
        logic          fits;

        assign shifted = den_reg[s] << K;
        assign fits    = (rem_reg[s] >= shifted);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[s+1] <= '0;
            end else if (adv) begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s+1] <= fits ? (rem_reg[s] - shifted) : rem_reg[s];
                den_reg[s+1] <= den_reg[s];
                quo_reg[s+1] <= quo_reg[s] | (fits ? (QW'(1) << K) : QW'(0));
            end
        end
    end

    logic [QW-1:0] lim;
    logic [QW-1:0] val;
    logic [QW-1:0] signed_val;

    always_comb begin
        lim        = (QW'(1) << (W - 1)) - (ctl_reg[NS].neg ? QW'(0) : QW'(1));
        val        = (ctl_reg[NS].ovf || (quo_reg[NS] > lim)) ? lim : quo_reg[NS];
        signed_val = ctl_reg[NS].neg ? (QW'(0) - val) : val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else if (adv) begin
            out_ctl_reg <= ctl_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_col_reg <= ctl_reg[NS].sing ? '0 : signed_val[W-1:0];
        end
    end

    assign out_ctl = out_ctl_reg;
    assign out_col = out_col_reg;

endmodule

`default_nettype wire

// ----- rtl/affine_matrix_inverse.sv -----
`default_nettype none

// Inverts an affine transform given as its top three rows of signed fixed-point
// values (the bottom row 0,0,0,1 is implied). One input item carries the twelve
// entries; the block answers with three result items, the inverse rows 0, 1 and
// 2 in that order, the last one marked by m_tlast. Each entry is the exact
// quotient rounded to nearest with ties away from zero and saturated to the
// signed DATA_WIDTH range. A zero determinant gives three all-zero rows with
// the singular flag in m_tuser set. The datapath works on one result row per
// cycle while m_tready does not stall it, and the block takes a new matrix
// while it issues the last row of the held one. The pipeline holds the six
// cofactor and determinant stages and the DATA_WIDTH + 3 stages of the four
// restoring divider lanes. A stalled m_tready freezes the whole pipeline.
module affine_matrix_inverse #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23 from bit 0 up
    input  wire logic [((12*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // col0, col1, col2, col3 from bit 0 up
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    // row_index (bits 1:0), singular (bit 2)
    output logic [7:0]                                m_tuser,
    output logic                                      m_tlast
);
    import ami_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;          // one cofactor product
    localparam int AW  = 2 * W + 1;      // one cofactor
    localparam int HW  = 2 * W + 2;      // half of a cofactor times an entry
    localparam int SW  = 3 * W + 2;      // determinant and translation sums
    localparam int NW  = 4 * W + 2 * F + 4;
    localparam int TDO = ((4 * DATA_WIDTH + 7) / 8) * 8;

    // The pipeline moves as a whole whenever the output register can take a row.
    logic adv;
    assign adv = !m_tvalid || m_tready;

    // ---------------- Input hold: one matrix, issued as three rows ----------------
    logic                hold_valid_reg;
    logic [1:0]          cnt_reg;
    logic [12*W-1:0]     mat_reg;

    assign s_tready = adv && (!hold_valid_reg || (cnt_reg == ROW_LAST));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= ROW_FIRST;
        end else if (adv) begin
            if (s_tvalid && s_tready) begin
                hold_valid_reg <= 1'b1;
                cnt_reg        <= ROW_FIRST;
            end else if (hold_valid_reg) begin
                if (cnt_reg == ROW_LAST) begin
                    hold_valid_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mat_reg <= s_tdata[12*W-1:0];
        end
    end

    logic signed [W-1:0] mat [0:2][0:3];
    for (genvar r = 0; r < 3; r++) begin : g_mat_r
        for (genvar c = 0; c < 4; c++) begin : g_mat_c
            assign mat[r][c] = $signed(mat_reg[(r*4+c)*W +: W]);
        end
    end

    // Columns of the cofactors that form row i of the adjugate.
    logic [1:0] col_a;
    logic [1:0] col_b;
    assign col_a = (cnt_reg == ROW_LAST)  ? ROW_FIRST : cnt_reg + 2'd1;
    assign col_b = (cnt_reg == ROW_FIRST) ? ROW_LAST  : cnt_reg - 2'd1;

    // ---------------- Stage 1: cofactor products ----------------
    ctl_t                c1_reg;
    logic signed [PW-1:0] pp_reg [0:2];
    logic signed [PW-1:0] pq_reg [0:2];
    logic signed [PW-1:0] cp_reg [0:2];
    logic signed [PW-1:0] cq_reg [0:2];
    logic signed [W-1:0]  a0_1_reg [0:2];
    logic signed [W-1:0]  tv_1_reg [0:2];
    ctl_t                 c1_next;

    always_comb begin
        c1_next           = '0;
        c1_next.valid     = hold_valid_reg;
        c1_next.row_index = cnt_reg;
        c1_next.last_row  = (cnt_reg == ROW_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
        end else if (adv) begin
            c1_reg <= c1_next;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_s1
        localparam int R1 = (j + 1) % 3;
        localparam int R2 = (j + 2) % 3;
        always_ff @(posedge aclk) begin
            if (adv) begin
                // adjugate entry (i, j) is the cofactor of entry (j, i)
                pp_reg[j]   <= mat[R1][col_a] * mat[R2][col_b];
                pq_reg[j]   <= mat[R1][col_b] * mat[R2][col_a];
                // column 0 of the adjugate, for the determinant
                cp_reg[j]   <= mat[1][R1] * mat[2][R2];
                cq_reg[j]   <= mat[1][R2] * mat[2][R1];
                a0_1_reg[j] <= mat[0][j];
                tv_1_reg[j] <= mat[j][3];
            end
        end
    end

    // ---------------- Stage 2: cofactors ----------------
    ctl_t                 c2_reg;
    logic signed [AW-1:0] adj_2_reg  [0:2];
    logic signed [AW-1:0] adjc_2_reg [0:2];
    logic signed [W-1:0]  a0_2_reg   [0:2];
    logic signed [W-1:0]  tv_2_reg   [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_reg <= '0;
        end else if (adv) begin
            c2_reg <= c1_reg;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_s2
        always_ff @(posedge aclk) begin
            if (adv) begin
                adj_2_reg[j]  <= AW'(pp_reg[j]) - AW'(pq_reg[j]);
                adjc_2_reg[j] <= AW'(cp_reg[j]) - AW'(cq_reg[j]);
                a0_2_reg[j]   <= a0_1_reg[j];
                tv_2_reg[j]   <= tv_1_reg[j];
            end
        end
    end

    // ---------------- Stage 3: half products of cofactor and entry ----------------
    ctl_t                 c3_reg;
    logic signed [HW-1:0] dlo_reg [0:2];
    logic signed [HW-1:0] dhi_reg [0:2];
    logic signed [HW-1:0] tlo_reg [0:2];
    logic signed [HW-1:0] thi_reg [0:2];
    logic signed [AW-1:0] adj_3_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg <= '0;
        end else if (adv) begin
            c3_reg <= c2_reg;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_s3
        always_ff @(posedge aclk) begin
            if (adv) begin
                dlo_reg[j]   <= a0_2_reg[j] * $signed({1'b0, adjc_2_reg[j][W-1:0]});
                dhi_reg[j]   <= a0_2_reg[j] * $signed(adjc_2_reg[j][AW-1:W]);
                tlo_reg[j]   <= tv_2_reg[j] * $signed({1'b0, adj_2_reg[j][W-1:0]});
                thi_reg[j]   <= tv_2_reg[j] * $signed(adj_2_reg[j][AW-1:W]);
                adj_3_reg[j] <= adj_2_reg[j];
            end
        end
    end

    // ---------------- Stage 4: full products ----------------
    ctl_t                 c4_reg;
    logic signed [SW-1:0] dterm_reg [0:2];
    logic signed [SW-1:0] tterm_reg [0:2];
    logic signed [AW-1:0] adj_4_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c4_reg <= '0;
        end else if (adv) begin
            c4_reg <= c3_reg;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_s4
        always_ff @(posedge aclk) begin
            if (adv) begin
                dterm_reg[j] <= (SW'(dhi_reg[j]) <<< W) + SW'(dlo_reg[j]);
                tterm_reg[j] <= (SW'(thi_reg[j]) <<< W) + SW'(tlo_reg[j]);
                adj_4_reg[j] <= adj_3_reg[j];
            end
        end
    end

    // ---------------- Stage 5: determinant and translation numerator ----------------
    ctl_t                 c5_reg;
    logic signed [SW-1:0] det_reg;
    logic signed [SW-1:0] tnum_reg;
    logic signed [AW-1:0] adj_5_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c5_reg <= '0;
        end else if (adv) begin
            c5_reg <= c4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg   <= dterm_reg[0] + dterm_reg[1] + dterm_reg[2];
            tnum_reg  <= tterm_reg[0] + tterm_reg[1] + tterm_reg[2];
            adj_5_reg <= adj_4_reg;
        end
    end

    // ---------------- Stage 6: magnitudes, signs and rounding offsets ----------------
    // Each lane divides (2|num| * 2^shift + |det|) by 2|det|, which rounds to nearest
    // with ties away from zero. The translation numerator is negated.
    logic [SW-1:0] det_mag;
    logic [SW-1:0] tnum_mag;
    logic          det_neg;
    logic          sing_next;
    logic [NW-1:0] num_next [0:NUM_LANES-1];
    logic          neg_next [0:NUM_LANES-1];
    ctl_t          lane_ctl_next [0:NUM_LANES-1];

    always_comb begin
        det_neg   = det_reg[SW-1];
        det_mag   = det_neg ? SW'(-det_reg) : SW'(det_reg);
        tnum_mag  = tnum_reg[SW-1] ? SW'(-tnum_reg) : SW'(tnum_reg);
        sing_next = (det_reg == '0);
        for (int j = 0; j < 3; j++) begin
            num_next[j] = (NW'(adj_5_reg[j][AW-1] ? AW'(-adj_5_reg[j]) : AW'(adj_5_reg[j]))
                           << (2 * F + 1)) + NW'(det_mag);
            neg_next[j] = (adj_5_reg[j] != '0) && (adj_5_reg[j][AW-1] != det_neg);
        end
        num_next[3] = (NW'(tnum_mag) << (F + 1)) + NW'(det_mag);
        neg_next[3] = (tnum_reg != '0) && (!tnum_reg[SW-1] != det_neg);
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_ctl_next[l]      = c5_reg;
            lane_ctl_next[l].sing = sing_next;
            lane_ctl_next[l].neg  = neg_next[l];
        end
    end

    ctl_t          lane_ctl_reg [0:NUM_LANES-1];
    logic [NW-1:0] lane_num_reg [0:NUM_LANES-1];
    logic [NW-1:0] lane_den_reg;
    ctl_t          lane_out_ctl [0:NUM_LANES-1];
    logic [W-1:0]  lane_out_col [0:NUM_LANES-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_den_reg <= NW'(det_mag) << 1;
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lane_ctl_reg[l] <= '0;
            end else if (adv) begin
                lane_ctl_reg[l] <= lane_ctl_next[l];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                lane_num_reg[l] <= num_next[l];
            end
        end

        ami_div_lane #(
            .DATA_WIDTH (W),
            .NUM_WIDTH  (NW)
        ) u_div_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .in_ctl  (lane_ctl_reg[l]),
            .in_num  (lane_num_reg[l]),
            .in_den  (lane_den_reg),
            .out_ctl (lane_out_ctl[l]),
            .out_col (lane_out_col[l])
        );
    end

    // ---------------- Output: the last lane stage is the output register ----------------
    assign m_tvalid = lane_out_ctl[0].valid;
    assign m_tlast  = lane_out_ctl[0].last_row;
    assign m_tuser  = {5'd0, lane_out_ctl[0].sing, lane_out_ctl[0].row_index};
    assign m_tdata  = TDO'({lane_out_col[3], lane_out_col[2], lane_out_col[1],
                            lane_out_col[0]});

`ifndef SYNTHESIS
    // No new matrix while the held one still has rows to issue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && (cnt_reg != ROW_LAST)) |-> !s_tready)
        else $error("input taken while a matrix is still being issued");

    // The row counter stays within the three rows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (cnt_reg == ROW_FIRST || cnt_reg == 2'd1 || cnt_reg == ROW_LAST))
        else $error("row counter out of range");

    // The last flag marks exactly the third row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == ROW_LAST)))
        else $error("last flag does not match row index");

    // A singular matrix gives zero entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == '0))
        else $error("nonzero entries on a singular matrix");

    // Lanes 0 and 3 carry the same row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        lane_out_ctl[0].valid |-> (lane_out_ctl[3].valid
            && (lane_out_ctl[3].row_index == lane_out_ctl[0].row_index)))
        else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire
